FILE: sv/simon_pkg.sv
package simon_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int WORD_W     = 16;
    localparam int KEY_WORDS  = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic        CMD_ENC = 1'b0;
    localparam logic        CMD_DEC = 1'b1;

    // z0 sequence, bit 0 first
    localparam logic [63:0] Z0_SEQ   = 64'h19C3522FB386A45F;
    localparam logic [15:0] KS_CONST = 16'hfffc;

    // element 0 is key word 0
    localparam logic [KEY_WORDS-1:0][WORD_W-1:0] KEY_RST =
        {16'h0100, 16'h0908, 16'h1110, 16'h1918};

    typedef logic [ROUNDS_DEF-1:0][WORD_W-1:0] rk_array_t;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] data_hi;
        logic [WORD_W-1:0] data_lo;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_hi;
        logic [WORD_W-1:0] result_lo;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic dec;
    } ks_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic dec;
    } rnd_ctrl_t;

    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x);
        return ({x[14:0], x[15]} & {x[7:0], x[15:8]}) ^ {x[13:0], x[15:14]};
    endfunction

    // k[i] from k[i-4], k[i-3], k[i-1] and the z bit
    function automatic logic [WORD_W-1:0] key_next(
        input logic [WORD_W-1:0] km4,
        input logic [WORD_W-1:0] km3,
        input logic [WORD_W-1:0] km1,
        input logic              zb
    );
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] t2;
        t  = {km1[2:0], km1[15:3]} ^ km3;
        t2 = t ^ {t[0], t[15:1]};
        return km4 ^ t2 ^ KS_CONST ^ {{(WORD_W-1){1'b0}}, zb};
    endfunction

    // elaboration-time only: reset contents of the round key store
    function automatic rk_array_t expand_keys(input logic [KEY_WORDS-1:0][WORD_W-1:0] kw);
        rk_array_t rk;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            rk[i] = kw[i];
        end
        for (int i = KEY_WORDS; i < ROUNDS_DEF; i++)
        begin
            rk[i] = key_next(rk[i-4], rk[i-3], rk[i-1], Z0_SEQ[(i - 4) % 62]);
        end
        return rk;
    endfunction

    localparam rk_array_t RK_RST = expand_keys(KEY_RST);

endpackage

FILE: sv/simon_key_sched.sv
module simon_key_sched #(
    parameter int ROUNDS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [simon_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [simon_pkg::WORD_W-1:0]     cfg_data,
    input  simon_pkg::ks_ctrl_t              ctrl,
    output logic [simon_pkg::WORD_W-1:0]     round_key,
    output logic                             busy
);
    import simon_pkg::*;

    localparam int CNT_W = $clog2(ROUNDS + 1);
    localparam int KI_W  = $clog2(KEY_WORDS);

    logic [WORD_W-1:0] kw_reg   [KEY_WORDS];
    logic [WORD_W-1:0] kw_next  [KEY_WORDS];
    logic [WORD_W-1:0] win_reg  [KEY_WORDS];
    logic [WORD_W-1:0] rk_reg   [ROUNDS];
    logic [CNT_W-1:0]  cnt_reg;
    logic              key_wr;
    logic [WORD_W-1:0] new_key;

    assign key_wr  = cfg_wr_en && (cfg_index < CFG_IDX_W'(KEY_WORDS));
    assign busy    = (cnt_reg != CNT_W'(ROUNDS));
    assign new_key = key_next(win_reg[0], win_reg[1], win_reg[3], Z0_SEQ[cnt_reg]);

    always_comb
    begin
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            kw_next[i] = kw_reg[i];
        end
        if (key_wr)
        begin
            kw_next[cfg_index[KI_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                kw_reg[i] <= KEY_RST[i];
            end
            cnt_reg <= CNT_W'(ROUNDS);
        end
        else
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                kw_reg[i] <= kw_next[i];
            end
            if (key_wr)
            begin
                cnt_reg <= '0;
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // four-word window of the schedule recurrence
    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                win_reg[i] <= kw_next[i];
            end
        end
        else if (busy)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= new_key;
        end
    end

    // circular key line: entry 0 is the next encryption key, the last entry
    // the next decryption key; ROUNDS rotations bring it back in place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUNDS; i++)
            begin
                rk_reg[i] <= RK_RST[i];
            end
        end
        else if (busy)
        begin
            for (int i = 0; i < ROUNDS - 1; i++)
            begin
                rk_reg[i] <= rk_reg[i+1];
            end
            rk_reg[ROUNDS-1] <= win_reg[0];
        end
        else if (ctrl.step)
        begin
            if (ctrl.dec)
            begin
                for (int i = 1; i < ROUNDS; i++)
                begin
                    rk_reg[i] <= rk_reg[i-1];
                end
                rk_reg[0] <= rk_reg[ROUNDS-1];
            end
            else
            begin
                for (int i = 0; i < ROUNDS - 1; i++)
                begin
                    rk_reg[i] <= rk_reg[i+1];
                end
                rk_reg[ROUNDS-1] <= rk_reg[0];
            end
        end
    end

    assign round_key = ctrl.dec ? rk_reg[ROUNDS-1] : rk_reg[0];

endmodule

FILE: sv/simon_round_unit.sv
module simon_round_unit (
    input  logic                         clk,
    input  simon_pkg::rnd_ctrl_t         ctrl,
    input  simon_pkg::in_word_t          in_word,
    input  logic [simon_pkg::WORD_W-1:0] round_key,
    output simon_pkg::out_word_t         res_now,
    output simon_pkg::out_word_t         res_next
);
    import simon_pkg::*;

    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] x_next;
    logic [WORD_W-1:0] y_next;

    always_comb
    begin
        if (ctrl.dec)
        begin
            y_next = x_reg ^ round_f(y_reg) ^ round_key;
            x_next = y_reg;
        end
        else
        begin
            x_next = y_reg ^ round_f(x_reg) ^ round_key;
            y_next = x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= in_word.data_hi;
            y_reg <= in_word.data_lo;
        end
        else if (ctrl.step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign res_now  = '{result_hi: x_reg,  result_lo: y_reg};
    assign res_next = '{result_hi: x_next, result_lo: y_next};

endmodule

FILE: sv/simon_32_64_block_cipher.sv
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  in_data   (cmd, data_hi, data_lo)
// out       output     out_valid / out_stall out_data (result_hi, result_lo)
// cfg       input      cfg_wr_en            cfg_index, cfg_data (key words 0..3)
//
// One Feistel round per cycle; with the output register free a new word
// is taken on the edge of the last round.
// A key write re-expands the round key line, one key per cycle: in is stalled
// while keys are written and expanded. Reset loads the expanded reset keys.
// A held result does not stop the next block; it stops only at its last round.
module simon_32_64_block_cipher #(
    parameter int ROUNDS = simon_pkg::ROUNDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  simon_pkg::in_word_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output simon_pkg::out_word_t             out_data,
    input  logic                             cfg_wr_en,
    input  logic [simon_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [simon_pkg::WORD_W-1:0]     cfg_data
);
    import simon_pkg::*;

    localparam int RND_W = $clog2(ROUNDS);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [RND_W-1:0]  rnd_cnt_reg;
    logic              dec_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    ks_ctrl_t          ks_ctrl;
    rnd_ctrl_t         rnd_ctrl;
    logic [WORD_W-1:0] round_key;
    logic              ks_busy;
    out_word_t         res_now;
    out_word_t         res_next;

    logic              slot_free;
    logic              last_round;
    logic              in_accept;
    logic              load_next;
    logic              load_held;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign last_round = (state_reg == ST_RUN) && (rnd_cnt_reg == RND_W'(ROUNDS - 1));
    assign in_accept  = in_valid && !in_stall;
    assign load_next  = last_round && slot_free;
    assign load_held  = (state_reg == ST_WAIT) && slot_free;

    // idle takes a word unless the keys are being written or expanded;
    // a running block takes the next one only on its last round
    assign in_stall   = cfg_wr_en || ks_busy || ((state_reg != ST_IDLE) && !load_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_round)
                begin
                    if (!slot_free)
                    begin
                        state_next = ST_WAIT;
                    end
                    else if (!in_accept)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WAIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                rnd_cnt_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                rnd_cnt_reg <= rnd_cnt_reg + RND_W'(1);
            end
            if (load_next || load_held)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dec_reg <= (in_data.cmd == CMD_DEC);
        end
        if (load_next)
        begin
            out_data_reg <= res_next;
        end
        else if (load_held)
        begin
            out_data_reg <= res_now;
        end
    end

    assign ks_ctrl  = '{step: (state_reg == ST_RUN), dec: dec_reg};
    assign rnd_ctrl = '{load: in_accept, step: (state_reg == ST_RUN), dec: dec_reg};

    simon_key_sched #(
        .ROUNDS (ROUNDS)
    ) u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ks_ctrl),
        .round_key (round_key),
        .busy      (ks_busy)
    );

    simon_round_unit u_round_unit (
        .clk       (clk),
        .ctrl      (rnd_ctrl),
        .in_word   (in_data),
        .round_key (round_key),
        .res_now   (res_now),
        .res_next  (res_next)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
